/* sv/assert_macros.svh */
// assertion macros shared by the rtl files of the voice activity detector
// expects signals clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define EVAD_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons holds in the next cycle
`define EVAD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/evad_pkg.sv */
// constants, register indexes and event codes of the voice activity detector
// no dependencies
package evad_pkg;

  localparam int unsigned ENERGY_W = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MS16_W   = 16;
  localparam int unsigned CODE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // length of one analysed frame in ms
  localparam int unsigned FRAME_MS = 10;

  typedef logic [ENERGY_W-1:0] energy_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [MS16_W-1:0]   ms16_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // event codes
  localparam code_t EV_SILENCE_BEGIN = 2'd0;
  localparam code_t EV_SILENCE       = 2'd1;
  localparam code_t EV_VOICE_BEGIN   = 2'd2;
  localparam code_t EV_VOICE         = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t REG_START_THRESHOLD   = 3'd0;
  localparam cfg_idx_t REG_CEILING_THRESHOLD = 3'd1;
  localparam cfg_idx_t REG_VOICE_BEGIN_MS    = 3'd2;
  localparam cfg_idx_t REG_VOICE_END_MS      = 3'd3;
  localparam cfg_idx_t REG_INITIAL_ADJUST_MS = 3'd4;
  localparam cfg_idx_t REG_VOICE_ADJUST_MS   = 3'd5;

  // register reset values
  localparam energy_t START_THRESHOLD_RST   = 32'd130;
  localparam energy_t CEILING_THRESHOLD_RST = 32'd1300;
  localparam ms16_t   VOICE_BEGIN_MS_RST    = 16'd60;
  localparam ms16_t   VOICE_END_MS_RST      = 16'd850;
  localparam ms16_t   INITIAL_ADJUST_MS_RST = 16'd200;
  localparam ms16_t   VOICE_ADJUST_MS_RST   = 16'd0;

endpackage

/* sv/evad_in_if.sv */
// frame channel of the voice activity detector: valid, ready and frame fields
// depends on evad_pkg
interface evad_in_if;
  import evad_pkg::*;

  logic    valid;
  logic    ready;
  time_t   frame_time_ms;
  energy_t frame_energy;
  energy_t avg_energy;

  modport source (output valid, output frame_time_ms, output frame_energy,
                  output avg_energy, input ready);
  modport sink (input valid, input frame_time_ms, input frame_energy,
                input avg_energy, output ready);
endinterface

/* sv/evad_out_if.sv */
// event channel of the voice activity detector: valid, ready and event fields
// depends on evad_pkg
interface evad_out_if;
  import evad_pkg::*;

  logic  valid;
  logic  ready;
  code_t event_code;
  time_t event_time_ms;
  time_t voice_total_ms;
  ms16_t transition_count_ms;

  modport source (output valid, output event_code, output event_time_ms,
                  output voice_total_ms, output transition_count_ms, input ready);
  modport sink (input valid, input event_code, input event_time_ms,
                input voice_total_ms, input transition_count_ms, output ready);
endinterface

/* sv/energy_voice_activity_detector_top.sv */
// Energy-threshold voice activity detector. Each frame transaction on in_if
// (time, energy, running average energy) produces exactly one event transaction
// on out_if: silence begin, silence, voice begin or voice, with the frame time,
// the total voice ms seen so far and the ms counted toward the next state change.
// A frame is first captured in an input register; from there the
// threshold adjust, the voice decision and the silence/voice state update run as
// one short combinational pass and land in the result register together with
// the new state. Throughput is one frame per clock while out_if takes its
// events, as the state registers load together with the result register; the
// event shows on out_if after its frame has passed the input register and the
// result register. The input register keeps accepting while an event waits to
// be taken, so the block only stalls once both registers are full.
// depends on evad_pkg, evad_in_if, evad_out_if and assert_macros.svh
`include "assert_macros.svh"

module energy_voice_activity_detector_top #(
  parameter int unsigned FRAME_LEN_MS = evad_pkg::FRAME_MS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  evad_in_if.sink              in_if,
  evad_out_if.source           out_if,
  input  logic                 cfg_we,
  input  evad_pkg::cfg_idx_t   cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import evad_pkg::*;

  // configuration registers
  energy_t ceiling_threshold_r;
  ms16_t   voice_begin_ms_r;
  ms16_t   voice_end_ms_r;
  ms16_t   initial_adjust_ms_r;
  ms16_t   second_adjust_ms_r;

  // detector state
  logic    voice_state_r, voice_state_nxt;
  energy_t threshold_r,   threshold_nxt;
  ms16_t   transition_r,  transition_nxt;
  time_t   first_voice_r, first_voice_nxt;
  time_t   total_voice_r, total_voice_nxt;

  // input register stage
  logic    in_valid_r;
  time_t   in_time_r;
  energy_t in_energy_r;
  energy_t in_avg_r;

  // result register stage
  logic    out_valid_r;
  code_t   out_code_r,  code_nxt;
  time_t   out_time_r;
  time_t   out_total_r;
  ms16_t   out_count_r;

  logic advance;  // input register moves into the result register
  logic in_take;

  // adjust and decision terms
  time_t             second_adjust_time;
  logic              adjust_now;
  logic [ENERGY_W+1:0] avg_x3;
  energy_t           cand_sat, cand_cap, thr_used;
  logic              voice;
  logic [MS16_W:0]   tr_inc_full;
  ms16_t             tr_inc_sat;
  ms16_t             tr_step;

  assign advance = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take = in_if.valid && in_if.ready;

  // threshold raise at the initial adjust time, or a set delay after the
  // first voice begin when that second adjust is armed
  assign second_adjust_time = first_voice_r + TIME_W'(second_adjust_ms_r);
  assign adjust_now = (in_time_r == TIME_W'(initial_adjust_ms_r)) ||
                      ((second_adjust_ms_r != '0) && (first_voice_r != '0) &&
                       (in_time_r == second_adjust_time));

  // tripled average, saturated to 32 bits, then capped at the ceiling
  assign avg_x3   = {1'b0, in_avg_r, 1'b0} + {2'b00, in_avg_r};
  assign cand_sat = (avg_x3[ENERGY_W+1:ENERGY_W] != 2'b00) ? '1 : avg_x3[ENERGY_W-1:0];
  assign cand_cap = (cand_sat > ceiling_threshold_r) ? ceiling_threshold_r : cand_sat;
  // an adjust only ever raises the threshold
  assign thr_used = (adjust_now && (cand_cap > threshold_r)) ? cand_cap : threshold_r;

  assign voice = ((in_time_r > TIME_W'(initial_adjust_ms_r)) && (in_energy_r > thr_used)) ||
                 (in_energy_r > ceiling_threshold_r);

  // transition counter step saturates at the top of its 16-bit range
  assign tr_inc_full = {1'b0, transition_r} + (MS16_W+1)'(FRAME_LEN_MS);
  assign tr_inc_sat  = tr_inc_full[MS16_W] ? '1 : tr_inc_full[MS16_W-1:0];

  always_comb begin
    voice_state_nxt = voice_state_r;
    first_voice_nxt = first_voice_r;
    total_voice_nxt = voice ? total_voice_r + TIME_W'(FRAME_LEN_MS) : total_voice_r;
    threshold_nxt   = thr_used;
    code_nxt        = EV_SILENCE;
    if (!voice_state_r) begin
      // silence: count consecutive voice ms toward the begin limit
      tr_step = voice ? tr_inc_sat : '0;
      if (tr_step >= voice_begin_ms_r) begin
        voice_state_nxt = 1'b1;
        transition_nxt  = '0;
        code_nxt        = EV_VOICE_BEGIN;
        if (first_voice_r == '0) begin
          first_voice_nxt = in_time_r;
        end
      end else begin
        transition_nxt = tr_step;
        code_nxt       = EV_SILENCE;
      end
    end else begin
      // voice: count consecutive silence ms toward the end limit
      tr_step = voice ? '0 : tr_inc_sat;
      if (tr_step >= voice_end_ms_r) begin
        voice_state_nxt = 1'b0;
        transition_nxt  = '0;
        code_nxt        = EV_SILENCE_BEGIN;
      end else begin
        transition_nxt = tr_step;
        code_nxt       = EV_VOICE;
      end
    end
  end

  // configuration registers; a start threshold write goes straight into the
  // working threshold, which is all that register is used for
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_threshold_r <= CEILING_THRESHOLD_RST;
      voice_begin_ms_r    <= VOICE_BEGIN_MS_RST;
      voice_end_ms_r      <= VOICE_END_MS_RST;
      initial_adjust_ms_r <= INITIAL_ADJUST_MS_RST;
      second_adjust_ms_r  <= VOICE_ADJUST_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_THRESHOLD:   ;  // loads the working threshold below
        REG_CEILING_THRESHOLD: ceiling_threshold_r <= cfg_data[ENERGY_W-1:0];
        REG_VOICE_BEGIN_MS:    voice_begin_ms_r    <= cfg_data[MS16_W-1:0];
        REG_VOICE_END_MS:      voice_end_ms_r      <= cfg_data[MS16_W-1:0];
        REG_INITIAL_ADJUST_MS: initial_adjust_ms_r <= cfg_data[MS16_W-1:0];
        REG_VOICE_ADJUST_MS:   second_adjust_ms_r  <= cfg_data[MS16_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state, updated once per frame as it moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_state_r <= 1'b0;
      threshold_r   <= START_THRESHOLD_RST;
      transition_r  <= '0;
      first_voice_r <= '0;
      total_voice_r <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_START_THRESHOLD)) begin
        threshold_r <= cfg_data[ENERGY_W-1:0];
      end else if (advance) begin
        threshold_r <= threshold_nxt;
      end
      if (advance) begin
        voice_state_r <= voice_state_nxt;
        transition_r  <= transition_nxt;
        first_voice_r <= first_voice_nxt;
        total_voice_r <= total_voice_nxt;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_time_r   <= in_if.frame_time_ms;
      in_energy_r <= in_if.frame_energy;
      in_avg_r    <= in_if.avg_energy;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code_r  <= code_nxt;
      out_time_r  <= in_time_r;
      out_total_r <= total_voice_nxt;
      out_count_r <= transition_nxt;
    end
  end

  assign out_if.valid               = out_valid_r;
  assign out_if.event_code          = out_code_r;
  assign out_if.event_time_ms       = out_time_r;
  assign out_if.voice_total_ms      = out_total_r;
  assign out_if.transition_count_ms = out_count_r;

  // the working threshold only rises while frames are processed
  `EVAD_ASSERT_NEXT(a_thr_no_fall, advance && !cfg_we, threshold_r >= $past(threshold_r), "working threshold fell")
  // the event code reports the state left behind by its frame
  `EVAD_ASSERT_NEXT(a_code_state, advance, out_code_r[1] == voice_state_r, "event code disagrees with state")
  // begin events carry a zero transition count
  `EVAD_ASSERT(a_begin_zero, !(out_valid_r && ((out_code_r == EV_VOICE_BEGIN) || (out_code_r == EV_SILENCE_BEGIN))) || (out_count_r == '0), "begin event with nonzero count")

endmodule

/* bench/evad_event_checker.sv */
// event checker for the energy voice activity detector: watches the frame,
// event and register ports, predicts every event and compares it field by field
// depends on evad_pkg, evad_in_if and evad_out_if
module evad_event_checker
  import evad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  evad_in_if                    in_ch,
  evad_out_if                   out_ch,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    pending_events
);

  localparam logic [MS16_W:0] FRAME_STEP = (MS16_W+1)'(FRAME_MS);

  typedef struct packed {
    code_t code;
    time_t at_ms;
    time_t voice_total;
    ms16_t trans_count;
  } vad_event_t;

  // register copies
  energy_t ceil_thr;
  ms16_t   begin_limit;
  ms16_t   end_limit;
  ms16_t   init_adjust;
  ms16_t   voice_adjust;

  // detector state
  logic    voice_state;
  energy_t threshold;
  ms16_t   trans_ms;
  time_t   first_voice_ms;
  time_t   voice_total_ms;

  vad_event_t expected_events[$];
  int         fails = 0;

  assign error_count = fails;

  // transition counter step, held at the top of its range
  function automatic ms16_t bump_ms(ms16_t v);
    logic [MS16_W:0] sum;
    sum = {1'b0, v} + FRAME_STEP;
    return sum[MS16_W] ? '1 : sum[MS16_W-1:0];
  endfunction

  // advances the detector state by one frame and returns the event it gives
  function automatic vad_event_t next_event(time_t t, energy_t e, energy_t avg);
    logic [ENERGY_W+1:0] tripled;
    energy_t             raised;
    logic                is_voice;
    vad_event_t          ev;
    if (t == time_t'(init_adjust) ||
        (voice_adjust != '0 && first_voice_ms != '0 &&
         t == time_t'(voice_adjust) + first_voice_ms)) begin
      tripled = {2'b00, avg} + {1'b0, avg, 1'b0};
      raised  = (tripled[ENERGY_W+1:ENERGY_W] != 2'b00) ? '1 : tripled[ENERGY_W-1:0];
      if (raised > ceil_thr) raised = ceil_thr;
      if (raised > threshold) threshold = raised;
    end
    is_voice = (t > time_t'(init_adjust) && e > threshold) || e > ceil_thr;
    if (is_voice) voice_total_ms = voice_total_ms + time_t'(FRAME_MS);
    if (!voice_state) begin
      trans_ms = is_voice ? bump_ms(trans_ms) : '0;
      if (trans_ms >= begin_limit) begin
        voice_state = 1'b1;
        trans_ms = '0;
        if (first_voice_ms == '0) first_voice_ms = t;
        ev.code = EV_VOICE_BEGIN;
      end else begin
        ev.code = EV_SILENCE;
      end
    end else begin
      trans_ms = is_voice ? '0 : bump_ms(trans_ms);
      if (trans_ms >= end_limit) begin
        voice_state = 1'b0;
        trans_ms = '0;
        ev.code  = EV_SILENCE_BEGIN;
      end else begin
        ev.code = EV_VOICE;
      end
    end
    ev.at_ms       = t;
    ev.voice_total = voice_total_ms;
    ev.trans_count = trans_ms;
    return ev;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    vad_event_t want;
    if (!rst_n) begin
      ceil_thr       = CEILING_THRESHOLD_RST;
      begin_limit    = VOICE_BEGIN_MS_RST;
      end_limit      = VOICE_END_MS_RST;
      init_adjust    = INITIAL_ADJUST_MS_RST;
      voice_adjust   = VOICE_ADJUST_MS_RST;
      voice_state    = 1'b0;
      threshold      = START_THRESHOLD_RST;
      trans_ms       = '0;
      first_voice_ms = '0;
      voice_total_ms = '0;
      expected_events.delete();
      pending_events <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_THRESHOLD:   threshold    = cfg_data;
          REG_CEILING_THRESHOLD: ceil_thr     = cfg_data;
          REG_VOICE_BEGIN_MS:    begin_limit  = cfg_data[MS16_W-1:0];
          REG_VOICE_END_MS:      end_limit    = cfg_data[MS16_W-1:0];
          REG_INITIAL_ADJUST_MS: init_adjust  = cfg_data[MS16_W-1:0];
          REG_VOICE_ADJUST_MS:   voice_adjust = cfg_data[MS16_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          fails++;
          $display("%0t: event with no frame pending, expected none, actual code %0d time %0d",
                   $time, out_ch.event_code, out_ch.event_time_ms);
        end else begin
          want = expected_events.pop_front();
          check_field("event_code", want.code, out_ch.event_code);
          check_field("event_time_ms", want.at_ms, out_ch.event_time_ms);
          check_field("voice_total_ms", want.voice_total, out_ch.voice_total_ms);
          check_field("transition_count_ms", want.trans_count, out_ch.transition_count_ms);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_events.push_back(next_event(in_ch.frame_time_ms, in_ch.frame_energy,
                                             in_ch.avg_energy));
      pending_events <= expected_events.size();
    end
  end

endmodule

/* bench/tb_energy_voice_activity_detector_top.sv */
// top of the voice activity detector bench: clock, reset, frame stimulus,
// register settings, event sink stalls, watchdog and the final verdict
// depends on evad_pkg, evad_in_if, evad_out_if, evad_event_checker and the rtl
module tb_energy_voice_activity_detector_top;
  import evad_pkg::*;

  localparam int RANDOM_PHASES    = 10;
  localparam int FRAMES_PER_PHASE = 180;
  // quiet frames after the closing voice begin, well past the end limit
  localparam int CLOSING_FRAMES   = 150;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 8;
  localparam int WATCHDOG_LIMIT   = 1000;
  // indexes past the last register, the block must ignore them
  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  typedef struct {
    energy_t start_thr;
    energy_t ceil_thr;
    ms16_t   begin_ms;
    ms16_t   end_ms;
    ms16_t   init_adjust;
    ms16_t   voice_adjust;
  } vad_settings_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int    error_count;
  int    pending_events;
  int    quiet_cycles = 0;
  int    frames_sent = 0;
  int    settings_used = 0;
  int    idle_pct = 20;
  bit    allow_idle = 1'b1;
  time_t stream_ms;

  evad_in_if  in_ch ();
  evad_out_if out_ch ();

  energy_voice_activity_detector_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // prediction and comparison live in the checker, the top only drives
  evad_event_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .error_count    (error_count),
    .pending_events (pending_events)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // event sink: ready drops in short random bursts while idling is allowed
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (allow_idle && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: any transaction or register write restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, run abandoned", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // pause the frame source until every predicted event has been taken
  // the pending count is registered, so the loop always waits on the clock first
  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // registers change only with the block idle; the 16 bit registers get
  // random upper data bits that must be dropped
  task automatic program_settings(input vad_settings_t s);
    wait_drained;
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_START_THRESHOLD, s.start_thr);
    write_reg(REG_CEILING_THRESHOLD, s.ceil_thr);
    write_reg(REG_VOICE_BEGIN_MS, {16'($urandom), s.begin_ms});
    write_reg(REG_VOICE_END_MS, {16'($urandom), s.end_ms});
    write_reg(REG_INITIAL_ADJUST_MS, {16'($urandom), s.init_adjust});
    write_reg(REG_VOICE_ADJUST_MS, {16'($urandom), s.voice_adjust});
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // one frame transaction; valid stays high across back-to-back frames
  task automatic send_frame(input time_t t, input energy_t e, input energy_t a);
    if (allow_idle && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.frame_time_ms <= t;
    in_ch.frame_energy  <= e;
    in_ch.avg_energy    <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    frames_sent++;
  endtask

  // energies meant to count as voice under the current registers
  function automatic energy_t loud_energy(vad_settings_t s);
    case ($urandom_range(0, 3))
      0: return (s.ceil_thr > 32'hFFFF_F000) ? '1 : s.ceil_thr + $urandom_range(1, 4000);
      1: return (s.start_thr > 32'hFFFF_0000) ? '1 : s.start_thr + $urandom_range(1, 60000);
      // right on the ceiling, voice only through the working threshold
      2: return s.ceil_thr;
      default: return '1;
    endcase
  endfunction

  // energies at or below the start threshold, never above the working one
  function automatic energy_t quiet_energy(vad_settings_t s);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return s.start_thr;
      default: return $urandom_range(0, s.start_thr);
    endcase
  endfunction

  function automatic energy_t pick_average(vad_settings_t s);
    case ($urandom_range(0, 5))
      0: return '1;
      1: return $urandom;
      // tripled value just at and past the saturation point
      2: return 32'h5555_5555 + $urandom_range(0, 2);
      default: return $urandom_range(0, s.ceil_thr / 3 + 200);
    endcase
  endfunction

  // alternating voice and silence runs sized around the begin and end limits, with
  // noise frames, time jumps and an occasional full drain mixed in
  task automatic run_frames(input vad_settings_t s, input int count);
    int      left;
    int      run_len;
    int      cap;
    bit      loud;
    energy_t e;
    left = count;
    loud = $urandom_range(0, 1);
    while (left > 0) begin
      cap = loud ? int'(s.begin_ms / FRAME_MS) + 3 : int'(s.end_ms / FRAME_MS) + 5;
      if (cap > 120) cap = 120;
      run_len = $urandom_range(1, cap);
      for (int i = 0; i < run_len && left > 0; i++) begin
        case ($urandom_range(0, 149))
          0:       stream_ms = $urandom;
          1, 2, 3: stream_ms = stream_ms + $urandom_range(1, 500);
          default: stream_ms = stream_ms + FRAME_MS;
        endcase
        if ($urandom_range(0, 19) == 0) e = $urandom;
        else e = loud ? loud_energy(s) : quiet_energy(s);
        send_frame(stream_ms, e, pick_average(s));
        left--;
        if ($urandom_range(0, 299) == 0) wait_drained;
      end
      loud = !loud;
    end
  endtask

  initial begin
    vad_settings_t s;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_START_THRESHOLD;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.frame_time_ms = '0;
    in_ch.frame_energy  = '0;
    in_ch.avg_energy    = '0;
    stream_ms           = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero limits: the state flips on every frame
    // first voice begin at time zero leaves the second adjust disarmed
    s.start_thr    = '0;
    s.ceil_thr     = '1;
    s.begin_ms     = '0;
    s.end_ms       = '0;
    s.init_adjust  = '0;
    s.voice_adjust = 16'd30;
    program_settings(s);
    send_frame(32'd0, 32'd0, 32'd0);
    send_frame(32'd0, 32'd0, 32'd0);
    // first voice late in time, so its second adjust time wraps to 20
    send_frame(32'hFFFF_FFF6, 32'd0, 32'd0);
    send_frame(32'd20, 32'd0, 32'h4000_0000);
    send_frame(32'd30, '1, 32'd5);

    // near-default registers: saturated and clipped adjust, ceiling edges
    s.start_thr    = 32'd130;
    s.ceil_thr     = 32'd1300;
    s.begin_ms     = 16'd20;
    s.end_ms       = 16'd30;
    s.init_adjust  = 16'd200;
    s.voice_adjust = '0;
    program_settings(s);
    send_frame(32'd200, 32'd150, 32'h6000_0000);
    send_frame(32'd210, 32'd1301, 32'd0);
    send_frame(32'd220, 32'd1300, 32'd0);
    send_frame(32'd230, 32'd0, 32'd0);
    send_frame(32'd240, 32'd0, 32'd0);
    send_frame(32'd250, '1, 32'd0);
    send_frame(32'd260, '1, 32'd0);
    send_frame(32'd270, '1, 32'd0);
    send_frame('1, '1, '1);
    send_frame(32'd0, 32'd0, 32'd0);

    // random phases: first all registers at zero, then all at maximum,
    // then mixed settings with varying idle rates
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        s.start_thr = '0; s.ceil_thr = '0; s.begin_ms = '0;
        s.end_ms = '0; s.init_adjust = '0; s.voice_adjust = '0;
      end else if (phase == 1) begin
        s.start_thr = '1; s.ceil_thr = '1; s.begin_ms = '1;
        s.end_ms = '1; s.init_adjust = '1; s.voice_adjust = '1;
      end else begin
        case ($urandom_range(0, 3))
          0:       s.start_thr = $urandom;
          1:       s.start_thr = '0;
          default: s.start_thr = $urandom_range(20, 400);
        endcase
        case ($urandom_range(0, 3))
          0:       s.ceil_thr = $urandom;
          1:       s.ceil_thr = '1;
          default: s.ceil_thr = $urandom_range(500, 3000);
        endcase
        case ($urandom_range(0, 4))
          0:       s.begin_ms = 16'($urandom);
          1:       s.begin_ms = '0;
          default: s.begin_ms = ms16_t'(10 * $urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 4))
          0:       s.end_ms = 16'($urandom);
          1:       s.end_ms = '0;
          default: s.end_ms = ms16_t'(10 * $urandom_range(1, 30));
        endcase
        case ($urandom_range(0, 4))
          0:       s.init_adjust = 16'($urandom);
          1:       s.init_adjust = '1;
          default: s.init_adjust = ms16_t'(10 * $urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 3))
          0:       s.voice_adjust = '0;
          1:       s.voice_adjust = 16'($urandom);
          default: s.voice_adjust = ms16_t'(10 * $urandom_range(1, 60));
        endcase
      end
      program_settings(s);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      stream_ms = ($urandom_range(0, 4) == 0) ? time_t'($urandom) : '0;
      run_frames(s, FRAMES_PER_PHASE);
    end

    // closing part, no idling: enter voice, then stay quiet past the end
    // limit so the block falls back to silence with frames back to back
    allow_idle     = 1'b0;
    s.start_thr    = 32'd50;
    s.ceil_thr     = 32'd100;
    s.begin_ms     = 16'd10;
    s.end_ms       = 16'd500;
    s.init_adjust  = '0;
    s.voice_adjust = '0;
    program_settings(s);
    stream_ms = '0;
    send_frame(stream_ms, 32'd1000, 32'd0);
    stream_ms = stream_ms + FRAME_MS;
    send_frame(stream_ms, 32'd1000, 32'd0);
    for (int i = 0; i < CLOSING_FRAMES; i++) begin
      stream_ms = stream_ms + FRAME_MS;
      send_frame(stream_ms, 32'd0, 32'd0);
    end

    wait_drained;
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d frames under %0d register settings, zero and maximum limits,",
             frames_sent, settings_used);
    $display("summary: threshold adjusts incl. wrap and saturation, back-to-back closing run");
    if (error_count == 0 && pending_events == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/evad_pkg.sv
sv/evad_in_if.sv
sv/evad_out_if.sv
sv/energy_voice_activity_detector_top.sv
bench/evad_event_checker.sv
bench/tb_energy_voice_activity_detector_top.sv
